// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e_t;

  // Bit index of the ack slot in a byte transfer.
  localparam logic [3:0] ACK_BIT = 4'd8;
  // Sub-phases of one bit (SCL low, high, low).
  localparam logic [1:0] SUB_LOW0 = 2'd0;
  localparam logic [1:0] SUB_HIGH = 2'd1;
  localparam logic [1:0] SUB_LOW1 = 2'd2;

  typedef struct packed {
    logic       cmd_valid;
    cmd_e_t     mode;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } result_t;

  typedef struct packed {
    logic fire;
    logic last;
    logic running;
  } eng_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/i2c_master_bit_engine_unit.sv =====
`default_nettype none
// Each accepted word is parked in the input queue and then registered as its result word.
// Throughput: one input word and one result word per cycle, sustained while neither side stalls.
// The input queue holds two words; the result register frees as it is taken.
// Reset (rst, synchronous, active high) empties the queue, drops m_tvalid and
// returns the engine to idle with SCL and SDA released high and ack_seen at 1.
`include "assert_macros.svh"
module i2c_master_bit_engine_unit import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // tx_byte[7:0], ack_out[8], sda_in[9], zero [15:10]
  input  wire logic [2:0]  s_tuser,  // cmd_valid[0], mode[2:1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // scl[0], sda[1], busy_res[2], rx_byte[10:3],
                                     // ack_seen[11], zero [15:12]
  output logic             m_tlast   // done_res: last phase tick of a command
);

  // Front: accept each tick word, classify it and park it in a two-entry queue.
  // Back: the bit engine consumes one tick word per cycle whenever its result
  // register is empty or being drained, so either side may stall on its own.

  q_head_t     head;
  logic        pop;
  result_t     res;
  eng_status_t status;

  i2cm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .pop      (pop),
    .head     (head)
  );

  i2cm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res),
    .status   (status)
  );

  // Pack the result word, lowest field first; done travels as tlast.
  assign m_tdata = {4'b0000, res.ack_seen, res.rx_byte, res.busy_res, res.sda, res.scl};
  assign m_tlast = res.done_res;

  // Never pop an empty queue.
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, pop, head.valid)
  // A finished command leaves the engine idle.
  `ASSERT_NEXT(a_idle_after_last, clk, rst, status.fire && status.last, !status.running)
  // A done word is always part of a busy sequence.
  `ASSERT_IMPLIES(a_done_busy, clk, rst, m_tvalid && m_tlast, m_tdata[2])

endmodule
`default_nettype wire

// ===== hw/rtl/i2cm_queue.sv =====
`default_nettype none
module i2cm_queue import i2cm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [15:0] s_tdata,  // tx_byte[7:0], ack_out[8], sda_in[9], zero pad
  input  wire logic [2:0] s_tuser,   // cmd_valid[0], mode[2:1]
  input  wire logic       pop,
  output q_head_t         head
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;

  // Classify the incoming word into a command item.
  always_comb begin
    in_item.cmd_valid = s_tuser[0];
    in_item.mode      = cmd_e_t'(s_tuser[2:1]);
    in_item.tx_byte   = s_tdata[7:0];
    in_item.ack_out   = s_tdata[8];
    in_item.sda_in    = s_tdata[9];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = mem[rd_ptr];

endmodule
`default_nettype wire

// ===== hw/rtl/i2cm_engine.sv =====
`default_nettype none
module i2cm_engine import i2cm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  q_head_t    head,
  output logic       pop,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output result_t    res,
  output eng_status_t status
);

  cmd_e_t     cmd;
  logic [3:0] bit_idx;
  logic [1:0] sub;
  logic [7:0] shift_reg;
  logic       ack_request;
  logic       running;
  logic       ack_latch;
  logic       scl_q;
  logic       sda_q;
  logic [7:0] rx_hold;

  cmd_e_t     cmd_next;
  logic [3:0] bit_next;
  logic [1:0] sub_next;
  logic [7:0] shift_next;
  logic       ack_request_next;
  logic       running_next;
  logic       ack_latch_next;
  logic       scl_next;
  logic       sda_next;
  logic [7:0] rx_hold_next;
  logic       last;
  logic       fire;
  logic       start;
  logic       writing;
  logic [7:0] shift_eff;
  logic [3:0] bit_eff;
  logic [1:0] sub_eff;

  assign fire = head.valid && (!m_tvalid || m_tready);
  assign pop  = fire;

  always_comb begin
    start            = !running && head.item.cmd_valid;
    cmd_next         = start ? head.item.mode : cmd;
    bit_eff          = start ? 4'd0 : bit_idx;
    sub_eff          = start ? SUB_LOW0 : sub;
    shift_eff        = shift_reg;
    ack_request_next = ack_request;
    if (start && head.item.mode == CMD_WRITE) begin
      shift_eff = head.item.tx_byte;
    end else if (start && head.item.mode == CMD_READ) begin
      shift_eff        = 8'd0;
      ack_request_next = head.item.ack_out;
    end
    running_next   = running || start;
    writing        = (cmd_next == CMD_WRITE);
    shift_next     = shift_eff;
    ack_latch_next = ack_latch;
    rx_hold_next   = rx_hold;
    scl_next       = scl_q;
    sda_next       = sda_q;
    last           = 1'b0;
    bit_next       = bit_eff;
    sub_next       = sub_eff;

    if (running_next) begin
      case (cmd_next)
        CMD_START: begin
          scl_next = (sub_eff != SUB_LOW1);
          sda_next = (sub_eff == SUB_LOW0);
          last     = (sub_eff == SUB_LOW1);
        end
        CMD_STOP: begin
          scl_next = (sub_eff != SUB_LOW0);
          sda_next = (sub_eff == SUB_LOW1);
          last     = (sub_eff == SUB_LOW1);
        end
        CMD_WRITE, CMD_READ: begin
          scl_next = (sub_eff == SUB_HIGH);
          last     = (bit_eff == ACK_BIT) && (sub_eff == SUB_LOW1);
          if (bit_eff != ACK_BIT) begin
            sda_next = writing ? shift_eff[7] : 1'b1;
            if (sub_eff == SUB_LOW1) begin
              shift_next = writing ? {shift_eff[6:0], 1'b0}
                                   : {shift_eff[6:0], head.item.sda_in};
            end
          end else begin
            sda_next = writing ? 1'b1 : ~ack_request_next;
            if (sub_eff == SUB_LOW1) begin
              if (writing) begin
                ack_latch_next = head.item.sda_in;
              end else begin
                rx_hold_next = shift_eff;
              end
            end
          end
        end
        default: begin
          last = 1'b1;
        end
      endcase
      // Advance the phase; drop back to idle after the last one.
      if (last) begin
        running_next = 1'b0;
        bit_next     = 4'd0;
        sub_next     = SUB_LOW0;
      end else if (sub_eff == SUB_LOW1) begin
        sub_next = SUB_LOW0;
        bit_next = bit_eff + 4'd1;
      end else begin
        sub_next = sub_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd         <= CMD_START;
      bit_idx     <= 4'd0;
      sub         <= SUB_LOW0;
      shift_reg   <= 8'd0;
      ack_request <= 1'b0;
      running     <= 1'b0;
      ack_latch   <= 1'b1;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_hold     <= 8'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (fire) begin
        cmd         <= cmd_next;
        bit_idx     <= bit_next;
        sub         <= sub_next;
        shift_reg   <= shift_next;
        ack_request <= ack_request_next;
        running     <= running_next;
        ack_latch   <= ack_latch_next;
        scl_q       <= scl_next;
        sda_q       <= sda_next;
        rx_hold     <= rx_hold_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.scl      <= scl_next;
      res.sda      <= sda_next;
      res.busy_res <= running || start;
      res.done_res <= (running || start) && last;
      res.rx_byte  <= rx_hold_next;
      res.ack_seen <= ack_latch_next;
    end
  end

  assign status.fire    = fire;
  assign status.last    = last && (running || start);
  assign status.running = running;

endmodule
`default_nettype wire

// ===== tb/sv/i2c_master_bit_engine_unit_checker.sv =====
`default_nettype none
// Watches both stream channels, predicts each result word from the accepted
// input words and compares the two in order.
module i2c_master_bit_engine_unit_checker import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,  // tx_byte[7:0], ack_out[8], sda_in[9], zero [15:10]
  input  wire logic [2:0]  s_tuser,  // cmd_valid[0], mode[2:1]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,  // scl[0], sda[1], busy_res[2], rx_byte[10:3],
                                     // ack_seen[11], zero [15:12]
  input  wire logic        m_tlast,  // done_res
  output int               errors,
  output int               pending
);

  // Shadow copy of the engine state.
  cmd_e_t     active_cmd;
  logic [4:0] phase;
  logic [7:0] shifter;
  logic       ack_req;
  logic       running;
  logic       ack_latch;
  logic       scl_lvl;
  logic       sda_lvl;
  logic [7:0] rx_hold;

  result_t bus_lines_due[$];

  task automatic reset_engine();
    active_cmd = CMD_START;
    phase      = '0;
    shifter    = '0;
    ack_req    = 1'b0;
    running    = 1'b0;
    ack_latch  = 1'b1;
    scl_lvl    = 1'b1;
    sda_lvl    = 1'b1;
    rx_hold    = '0;
  endtask

  // Advance the shadow engine by one bus tick and return the lines it drives.
  task automatic tick_engine(input item_t it, output result_t r);
    logic [4:0] p;
    logic [4:0] last_p;
    logic [4:0] bit_n;
    logic [1:0] sub;
    logic       writing;
    r = '0;
    r.scl = scl_lvl;
    r.sda = sda_lvl;
    if (!running && it.cmd_valid) begin
      active_cmd = it.mode;
      phase      = '0;
      running    = 1'b1;
      if (it.mode == CMD_WRITE) begin
        shifter = it.tx_byte;
      end else if (it.mode == CMD_READ) begin
        shifter = '0;
        ack_req = it.ack_out;
      end
    end
    if (running) begin
      p = phase;
      r.busy_res = 1'b1;
      case (active_cmd)
        CMD_START: begin
          last_p = 5'd2;
          {r.scl, r.sda} = (p == 5'd0) ? 2'b11 : (p == 5'd1) ? 2'b10 : 2'b00;
        end
        CMD_STOP: begin
          last_p = 5'd2;
          {r.scl, r.sda} = (p == 5'd0) ? 2'b00 : (p == 5'd1) ? 2'b10 : 2'b11;
        end
        default: begin
          last_p  = 5'd26;
          bit_n   = p / 5'd3;
          sub     = 2'(p % 5'd3);
          writing = (active_cmd == CMD_WRITE);
          r.scl   = (sub == SUB_HIGH);
          if (bit_n < 5'(ACK_BIT)) begin
            r.sda = writing ? shifter[7] : 1'b1;
            if (sub == SUB_LOW1) begin
              shifter = writing ? {shifter[6:0], 1'b0} : {shifter[6:0], it.sda_in};
            end
          end else begin
            r.sda = writing ? 1'b1 : ~ack_req;
            if (sub == SUB_LOW1) begin
              if (writing) begin
                ack_latch = it.sda_in;
              end else begin
                rx_hold = shifter;
              end
            end
          end
        end
      endcase
      scl_lvl = r.scl;
      sda_lvl = r.sda;
      if (p >= last_p) begin
        r.done_res = 1'b1;
        running    = 1'b0;
        phase      = '0;
      end else begin
        phase = p + 5'd1;
      end
    end
    r.rx_byte  = rx_hold;
    r.ack_seen = ack_latch;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      reset_engine();
      bus_lines_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.scl      = m_tdata[0];
        got.sda      = m_tdata[1];
        got.busy_res = m_tdata[2];
        got.done_res = m_tlast;
        got.rx_byte  = m_tdata[10:3];
        got.ack_seen = m_tdata[11];
        if (bus_lines_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %0h", $time, m_tdata);
        end else begin
          want = bus_lines_due.pop_front();
          check_field("scl", want.scl, got.scl);
          check_field("sda", want.sda, got.sda);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_seen", want.ack_seen, got.ack_seen);
        end
      end
      if (s_tvalid && s_tready) begin
        it.cmd_valid = s_tuser[0];
        it.mode      = cmd_e_t'(s_tuser[2:1]);
        it.tx_byte   = s_tdata[7:0];
        it.ack_out   = s_tdata[8];
        it.sda_in    = s_tdata[9];
        tick_engine(it, want);
        bus_lines_due.push_back(want);
      end
    end
    pending = bus_lines_due.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/i2c_master_bit_engine_unit_tb.sv =====
`default_nettype none
module i2c_master_bit_engine_unit_tb import i2cm_pkg::*; ();

  // Bus cycles with nothing accepted on either channel before the run is called hung.
  localparam int HANG_LIMIT = 2000;
  // Cycles to hold after the last expected word, to catch stray results.
  localparam int TAIL_CYCLES = 12;

  // How sda_in is filled during a command.
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // tx_byte[7:0], ack_out[8], sda_in[9], zero [15:10]
  logic [2:0]  s_tuser;   // cmd_valid[0], mode[2:1]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // scl[0], sda[1], busy_res[2], rx_byte[10:3],
                          // ack_seen[11], zero [15:12]
  logic        m_tlast;   // done_res

  int errors;
  int pending;

  // Idling knobs: percent of cycles the sender holds off / the receiver stalls.
  int gap_pct   = 0;
  int stall_pct = 0;
  // Percent of busy ticks that also offer a (to be ignored) command.
  int noise_pct = 0;

  // Ticks the engine still needs to finish the running command, as seen by
  // the stimulus side; zero means the next word can start a command.
  int ticks_left = 0;
  int tick_count = 0;
  int idle_cycles = 0;

  i2c_master_bit_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  i2c_master_bit_engine_unit_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: stall at random according to stall_pct.
  always @(posedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= HANG_LIMIT) begin
      $display("FAIL i2c_master_bit_engine_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic pick_sda(input int fill);
    case (fill)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1, 0));
    endcase
  endfunction

  // Offer one tick word and hold it until the block takes it.
  task automatic offer_tick(input logic cv, input cmd_e_t md, input logic [7:0] tx,
                            input logic ak, input logic sd);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {md, cv};
    s_tdata  <= {6'd0, sd, ak, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tick_count++;
    // Track the engine's own sequencing so commands land on idle ticks.
    if (ticks_left != 0) begin
      ticks_left--;
    end else if (cv) begin
      ticks_left = (md == CMD_WRITE || md == CMD_READ) ? 26 : 2;
    end
  endtask

  // Issue one command on an idle tick and feed ticks until it completes.
  // Busy ticks may carry noise commands that the engine has to drop.
  task automatic run_command(input cmd_e_t md, input logic [7:0] tx, input logic ak,
                             input int fill);
    offer_tick(1'b1, md, tx, ak, pick_sda(fill));
    while (ticks_left != 0) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        offer_tick(1'b1, cmd_e_t'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                   1'($urandom_range(1, 0)), pick_sda(fill));
      end else begin
        offer_tick(1'b0, md, tx, ak, pick_sda(fill));
      end
    end
  endtask

  // Random bus traffic: mostly complete commands, some bare idle ticks.
  task automatic random_traffic(input int n_ticks);
    int stop_at;
    stop_at = tick_count + n_ticks;
    while (tick_count < stop_at) begin
      if ($urandom_range(9, 0) == 0) begin
        offer_tick(1'b0, cmd_e_t'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                   1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      end else begin
        run_command(cmd_e_t'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), SDA_RAND);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick first, so the lines must show the released bus.
    offer_tick(1'b0, CMD_READ, 8'hff, 1'b1, 1'b1);
    run_command(CMD_START, 8'h00, 1'b0, SDA_RAND);
    // Write all ones and see a nack; write all zeros and see an ack.
    run_command(CMD_WRITE, 8'hff, 1'b0, SDA_HIGH);
    run_command(CMD_WRITE, 8'h00, 1'b1, SDA_LOW);
    run_command(CMD_WRITE, 8'ha5, 1'b0, SDA_RAND);
    // Reads of all ones and all zeros, with and without our ack.
    run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
    run_command(CMD_READ, 8'hff, 1'b0, SDA_LOW);
    // Commands offered on every busy tick must be dropped.
    noise_pct = 100;
    run_command(CMD_READ, 8'h5a, 1'b1, SDA_RAND);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND);
    noise_pct = 0;
    offer_tick(1'b0, CMD_WRITE, 8'h00, 1'b0, 1'b0);
    run_command(CMD_STOP, 8'hff, 1'b1, SDA_RAND);
    run_command(CMD_START, 8'hff, 1'b1, SDA_RAND);

    // Random traffic through the idling phases.
    noise_pct = 30;
    gap_pct = 0;  stall_pct = 0;  random_traffic(60);
    gap_pct = 63; stall_pct = 0;  random_traffic(60);
    gap_pct = 0;  stall_pct = 63; random_traffic(60);
    gap_pct = 29; stall_pct = 29; random_traffic(60);

    s_tvalid  <= 1'b0;
    stall_pct = 0;

    // Drain, then hold a few cycles to catch any stray result word.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("PASS i2c_master_bit_engine_unit");
    end else begin
      $display("FAIL i2c_master_bit_engine_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
